@@ rtl/cap_pkg.sv @@
// Shared types and constants for the cascaded attitude controller.
`timescale 1ns / 1ps
`default_nettype none
package cap_pkg;

    localparam int NLOOPS  = 5;
    localparam int GAIN_W  = 48;
    localparam int LIMIT_W = 15;

    // loop numbering: angle loops first, then the three rate loops
    typedef logic [2:0] t_loop;
    localparam t_loop LP_ANG_PITCH  = 3'd0;
    localparam t_loop LP_ANG_ROLL   = 3'd1;
    localparam t_loop LP_RATE_PITCH = 3'd2;
    localparam t_loop LP_RATE_ROLL  = 3'd3;
    localparam t_loop LP_RATE_YAW   = 3'd4;

    typedef enum logic [2:0] {
        REG_GAINS_ANGLE_PITCH = 3'd0,
        REG_GAINS_ANGLE_ROLL  = 3'd1,
        REG_GAINS_RATE_PITCH  = 3'd2,
        REG_GAINS_RATE_ROLL   = 3'd3,
        REG_GAINS_RATE_YAW    = 3'd4,
        REG_ANGLE_LIMIT       = 3'd5,
        REG_RATE_LIMIT        = 3'd6,
        REG_ACROBATIC         = 3'd7
    } t_reg_idx;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'h7FFF;

endpackage
`default_nettype wire

@@ rtl/cap_in_if.sv @@
// Input channel: one control tick request with sticks, attitude, rates and period.
`timescale 1ns / 1ps
`default_nettype none
interface cap_in_if;
    logic               valid;
    logic               ready;
    logic signed [10:0] stick_pitch;
    logic signed [10:0] stick_roll;
    logic signed [10:0] stick_yaw;
    logic signed [15:0] angle_pitch;
    logic signed [15:0] angle_roll;
    logic signed [15:0] rate_pitch;
    logic signed [15:0] rate_roll;
    logic signed [15:0] rate_yaw;
    logic        [15:0] period_us;

    modport source (output valid, stick_pitch, stick_roll, stick_yaw, angle_pitch,
                    angle_roll, rate_pitch, rate_roll, rate_yaw, period_us,
                    input ready);
    modport sink (input valid, stick_pitch, stick_roll, stick_yaw, angle_pitch,
                  angle_roll, rate_pitch, rate_roll, rate_yaw, period_us,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/cap_out_if.sv @@
// Output channel: the three drive values of one control tick.
`timescale 1ns / 1ps
`default_nettype none
interface cap_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive_pitch;
    logic signed [DATA_WIDTH-1:0] drive_roll;
    logic signed [DATA_WIDTH-1:0] drive_yaw;

    modport source (output valid, drive_pitch, drive_roll, drive_yaw, input ready);
    modport sink (input valid, drive_pitch, drive_roll, drive_yaw, output ready);
endinterface
`default_nettype wire

@@ rtl/cascaded_attitude_pid.sv @@
// Cascaded angle/rate PID attitude controller with one shared multiplier.
//
// Usage:
//   in_ch carries one control tick request (sticks, angles, gyro rates, period).
//   It is taken when valid and ready are high; ready is high only while idle.
//   out_ch presents drive_pitch/roll/yaw in an output register; the next
//   request is accepted while that result still waits for the receiver.
//   Gains, limits and mode are written over the APB port (8-byte stride,
//   pready always high); the user must do so only while no request is in
//   flight, as the block itself does not enforce this.
// Sequence:
//   Each stick/period division runs in a restoring divider (one quotient
//   bit per cycle): one in stable mode, three in acrobatic. Each PID loop
//   steps through S_ERR, S_MUL_I, S_INT, S_MUL_P, S_MUL_D, S_SUB and S_OUT
//   on the shared 17x17 multiplier and adder: five loops in stable mode,
//   three in acrobatic. A new request is taken only once the result of the
//   last one has been moved to the output register.
// Reset:
//   Integrals and last measurements clear to zero, gains to zero, both
//   limits to 32767, stable mode; the output channel goes empty.
// Stall:
//   A held result blocks the end of the next request until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module cascaded_attitude_pid #(
    parameter int DATA_WIDTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    cap_in_if.sink      in_ch,
    cap_out_if.source   out_ch,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [5:0]  paddr,
    input  wire  [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    localparam int DW = DATA_WIDTH;
    localparam logic signed [39:0] WMAX = 40'sd1 <<< (DW - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV_INIT, S_DIV, S_DIV_END, S_ERR, S_MUL_I, S_INT,
        S_MUL_P, S_MUL_D, S_SUB, S_OUT, S_FIN
    } t_state;

    t_state r_state;

    // configuration
    logic [cap_pkg::GAIN_W-1:0]  r_gains [cap_pkg::NLOOPS];
    logic [cap_pkg::LIMIT_W-1:0] r_angle_limit;
    logic [cap_pkg::LIMIT_W-1:0] r_rate_limit;
    logic                        r_acro;

    // loop state
    logic signed [15:0] r_integ [cap_pkg::NLOOPS];
    logic signed [15:0] r_last  [cap_pkg::NLOOPS];

    // captured request
    logic signed [10:0] r_stick [3];
    logic signed [15:0] r_meas  [cap_pkg::NLOOPS];
    logic        [15:0] r_div;

    // working registers
    cap_pkg::t_loop     r_idx;
    logic [1:0]         r_k;
    logic [3:0]         r_cnt;
    logic [15:0]        r_rem;
    logic [14:0]        r_quo;
    logic signed [15:0] r_sp [3];
    logic signed [16:0] r_err;
    logic signed [16:0] r_dm;
    logic signed [33:0] r_prod;
    logic signed [34:0] r_acc;
    logic signed [DW-1:0] r_drv [3];
    logic signed [DW-1:0] r_odrv [3];
    logic               r_ovld;

    function automatic logic signed [39:0] clamp40(input logic signed [39:0] v,
                                                   input logic signed [39:0] lo,
                                                   input logic signed [39:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // ---------------- APB ----------------
    logic w_wr;
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (cap_pkg::t_reg_idx'(paddr[5:3]))
            cap_pkg::REG_GAINS_ANGLE_PITCH: prdata = {16'd0, r_gains[0]};
            cap_pkg::REG_GAINS_ANGLE_ROLL:  prdata = {16'd0, r_gains[1]};
            cap_pkg::REG_GAINS_RATE_PITCH:  prdata = {16'd0, r_gains[2]};
            cap_pkg::REG_GAINS_RATE_ROLL:   prdata = {16'd0, r_gains[3]};
            cap_pkg::REG_GAINS_RATE_YAW:    prdata = {16'd0, r_gains[4]};
            cap_pkg::REG_ANGLE_LIMIT:       prdata = {49'd0, r_angle_limit};
            cap_pkg::REG_RATE_LIMIT:        prdata = {49'd0, r_rate_limit};
            cap_pkg::REG_ACROBATIC:         prdata = {63'd0, r_acro};
        endcase
    end

    // ---------------- datapath selects ----------------
    logic [47:0]        w_gain;
    logic signed [15:0] w_sp;
    logic signed [15:0] w_mv;
    logic signed [39:0] w_lim;
    logic signed [16:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [33:0] w_mul;
    logic               w_is_angle;

    assign w_is_angle = (r_idx == cap_pkg::LP_ANG_PITCH) || (r_idx == cap_pkg::LP_ANG_ROLL);
    assign w_gain     = r_gains[r_idx];
    assign w_mv       = r_meas[r_idx];
    assign w_lim      = w_is_angle ? 40'(r_angle_limit) : 40'(r_rate_limit);

    always_comb begin
        unique case (r_idx)
            cap_pkg::LP_ANG_PITCH:  w_sp = {r_stick[0][10], r_stick[0], 4'd0};
            cap_pkg::LP_ANG_ROLL:   w_sp = {r_stick[1][10], r_stick[1], 4'd0};
            cap_pkg::LP_RATE_PITCH: w_sp = r_sp[0];
            cap_pkg::LP_RATE_ROLL:  w_sp = r_sp[1];
            default:                w_sp = r_sp[2];
        endcase
    end

    // shared multiplier: gain (unsigned Q8.8) times error or measurement change
    always_comb begin
        unique case (r_state)
            S_MUL_I: begin
                w_mul_a = {1'b0, w_gain[31:16]};
                w_mul_b = r_err;
            end
            S_MUL_D: begin
                w_mul_a = {1'b0, w_gain[47:32]};
                w_mul_b = r_dm;
            end
            default: begin
                w_mul_a = {1'b0, w_gain[15:0]};
                w_mul_b = r_err;
            end
        endcase
    end
    assign w_mul = w_mul_a * w_mul_b;

    // integral update
    logic signed [39:0] w_int_sum;
    logic signed [39:0] w_int_new;
    assign w_int_sum = 40'(r_integ[r_idx]) + ((40'(r_prod) + 40'sd128) >>> 8);
    assign w_int_new = clamp40(w_int_sum, -w_lim, w_lim);

    // loop output
    logic signed [39:0] w_out_sum;
    logic signed [39:0] w_out_lim;
    logic signed [39:0] w_out;
    assign w_out_sum = ((40'(r_acc) + 40'sd128) >>> 8) + 40'(r_integ[r_idx]);
    assign w_out_lim = clamp40(w_out_sum, -w_lim, w_lim);
    assign w_out     = clamp40(w_out_lim, -WMAX, WMAX - 40'sd1);

    // divider step and result
    logic signed [10:0] w_stk;
    logic [10:0]        w_stk_abs;
    logic [17:0]        w_trial;
    logic signed [39:0] w_q;
    logic signed [39:0] w_qs;
    assign w_stk     = r_stick[r_k];
    assign w_stk_abs = w_stk[10] ? 11'(-w_stk) : w_stk;
    assign w_trial   = {1'b0, r_rem, r_quo[14]} - {2'b00, r_div};
    assign w_q       = w_stk[10] ? -40'(r_quo) : 40'(r_quo);
    assign w_qs      = clamp40(w_q, -WMAX, WMAX - 40'sd1);

    // ---------------- channels ----------------
    assign in_ch.ready        = (r_state == S_IDLE);
    assign out_ch.valid       = r_ovld;
    assign out_ch.drive_pitch = r_odrv[0];
    assign out_ch.drive_roll  = r_odrv[1];
    assign out_ch.drive_yaw   = r_odrv[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ovld        <= 1'b0;
            r_angle_limit <= cap_pkg::LIMIT_RESET;
            r_rate_limit  <= cap_pkg::LIMIT_RESET;
            r_acro        <= 1'b0;
            for (int i = 0; i < cap_pkg::NLOOPS; i++) begin
                r_gains[i] <= '0;
                r_integ[i] <= '0;
                r_last[i]  <= '0;
            end
        end else begin
            if (w_wr) begin
                unique case (cap_pkg::t_reg_idx'(paddr[5:3]))
                    cap_pkg::REG_GAINS_ANGLE_PITCH: r_gains[0] <= pwdata[47:0];
                    cap_pkg::REG_GAINS_ANGLE_ROLL:  r_gains[1] <= pwdata[47:0];
                    cap_pkg::REG_GAINS_RATE_PITCH:  r_gains[2] <= pwdata[47:0];
                    cap_pkg::REG_GAINS_RATE_ROLL:   r_gains[3] <= pwdata[47:0];
                    cap_pkg::REG_GAINS_RATE_YAW:    r_gains[4] <= pwdata[47:0];
                    cap_pkg::REG_ANGLE_LIMIT:       r_angle_limit <= pwdata[14:0];
                    cap_pkg::REG_RATE_LIMIT:        r_rate_limit <= pwdata[14:0];
                    cap_pkg::REG_ACROBATIC:         r_acro <= pwdata[0];
                endcase
            end

            // S_FIN reloads the output register itself
            if (r_ovld && out_ch.ready && (r_state != S_FIN)) r_ovld <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_stick[0] <= in_ch.stick_pitch;
                        r_stick[1] <= in_ch.stick_roll;
                        r_stick[2] <= in_ch.stick_yaw;
                        r_meas[0]  <= in_ch.angle_pitch;
                        r_meas[1]  <= in_ch.angle_roll;
                        r_meas[2]  <= in_ch.rate_pitch;
                        r_meas[3]  <= in_ch.rate_roll;
                        r_meas[4]  <= in_ch.rate_yaw;
                        // zero period counts as one
                        r_div      <= (in_ch.period_us == 16'd0) ? 16'd1 : in_ch.period_us;
                        r_k        <= r_acro ? 2'd0 : 2'd2;
                        r_state    <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    r_rem   <= '0;
                    r_quo   <= {w_stk_abs, 4'd0};
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_trial[17]) begin
                        r_rem <= w_trial[15:0];
                        r_quo <= {r_quo[13:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[14:0], r_quo[14]};
                        r_quo <= {r_quo[13:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd14) r_state <= S_DIV_END;
                end
                S_DIV_END: begin
                    r_sp[r_k] <= w_qs[15:0];
                    if (r_k == 2'd2) begin
                        r_idx   <= r_acro ? cap_pkg::LP_RATE_PITCH : cap_pkg::LP_ANG_PITCH;
                        r_state <= S_ERR;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_DIV_INIT;
                    end
                end
                S_ERR: begin
                    r_err   <= 17'(w_sp) - 17'(w_mv);
                    r_dm    <= 17'(w_mv) - 17'(r_last[r_idx]);
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_prod  <= w_mul;
                    r_state <= S_INT;
                end
                S_INT: begin
                    r_integ[r_idx] <= w_int_new[15:0];
                    r_state        <= S_MUL_P;
                end
                S_MUL_P: begin
                    r_prod  <= w_mul;
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_acc   <= 35'(r_prod);
                    r_prod  <= w_mul;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_acc   <= r_acc - 35'(r_prod);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_last[r_idx] <= w_mv;
                    if (w_is_angle) r_sp[r_idx[1:0]] <= w_out[15:0];
                    else r_drv[2'(r_idx - cap_pkg::LP_RATE_PITCH)] <= w_out[DW-1:0];
                    if (r_idx == cap_pkg::LP_RATE_YAW) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= r_idx + 3'd1;
                        r_state <= S_ERR;
                    end
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_ovld || out_ch.ready) begin
                        r_odrv[0] <= r_drv[0];
                        r_odrv[1] <= r_drv[1];
                        r_odrv[2] <= r_drv[2];
                        r_ovld    <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/cap_checker.sv @@
// Port-level checks for the cascaded attitude controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cap_checker #(
    parameter int DATA_WIDTH = 16
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  i_in_ready,
    input wire                  i_out_valid,
    input wire                  i_out_ready,
    input wire [DATA_WIDTH-1:0] i_drive_pitch
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drive_pitch))
        else $error("result dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while busy");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared right after a request");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind cascaded_attitude_pid cap_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (in_ch.valid),
    .i_in_ready    (in_ch.ready),
    .i_out_valid   (out_ch.valid),
    .i_out_ready   (out_ch.ready),
    .i_drive_pitch (out_ch.drive_pitch)
);
`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the cascaded attitude PID controller.
`timescale 1ns / 1ps
module tb;

    localparam int DW        = 16;
    localparam int IDLE_WAIT = 200;
    localparam int WATCHDOG  = 20000;

    typedef struct packed {
        logic signed [10:0] sp, sr, sy;
        logic signed [15:0] ap, ar, wp, wr, wy;
        logic        [15:0] per;
    } t_tick;

    typedef struct packed {
        logic signed [15:0] p, r, y;
    } t_drive;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    cap_in_if in_ch ();
    cap_out_if #(.DATA_WIDTH(DW)) out_ch ();

    cascaded_attitude_pid #(.DATA_WIDTH(DW)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // controller shadow state
    logic [47:0] gain_set [cap_pkg::NLOOPS];
    longint      ang_lim, rate_lim;
    bit          acro;
    longint      integ [cap_pkg::NLOOPS];
    longint      last_meas [cap_pkg::NLOOPS];

    t_drive drive_q [$];
    int     mismatches = 0;
    int     idle_cycles = 0;
    bit     hold_off = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.stick_pitch = '0; in_ch.stick_roll = '0; in_ch.stick_yaw = '0;
        in_ch.angle_pitch = '0; in_ch.angle_roll = '0; in_ch.rate_pitch = '0;
        in_ch.rate_roll = '0; in_ch.rate_yaw = '0; in_ch.period_us = 16'd1;
        out_ch.ready = 1'b0;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q.12 product to Q12.4, round half up
    function automatic longint q12_to_q4(longint v);
        return (v + 128) >>> 8;
    endfunction

    function automatic longint pid_step(cap_pkg::t_loop idx, longint sp, longint meas,
                                        longint lim);
        longint kp, ki, kd, err, o;
        kp = longint'(gain_set[idx][15:0]);
        ki = longint'(gain_set[idx][31:16]);
        kd = longint'(gain_set[idx][47:32]);
        err = sp - meas;
        integ[idx] = clip(integ[idx] + q12_to_q4(ki * err), -lim, lim);
        o = q12_to_q4(kp * err - kd * (meas - last_meas[idx])) + integ[idx];
        o = clip(o, -lim, lim);
        o = clip(o, -(64'sd1 <<< (DW - 1)), (64'sd1 <<< (DW - 1)) - 1);
        last_meas[idx] = meas;
        return o;
    endfunction

    function automatic longint stick_over_period(longint stick, longint per);
        longint p;
        p = (per == 0) ? 1 : per;
        return clip((stick * 16) / p, -(64'sd1 <<< (DW - 1)), (64'sd1 <<< (DW - 1)) - 1);
    endfunction

    function automatic t_drive predict_drive(t_tick t);
        longint rp, rr, ry;
        t_drive d;
        if (acro) begin
            rp = stick_over_period(longint'(t.sp), longint'(t.per));
            rr = stick_over_period(longint'(t.sr), longint'(t.per));
        end else begin
            rp = pid_step(cap_pkg::LP_ANG_PITCH, longint'(t.sp) * 16, longint'(t.ap), ang_lim);
            rr = pid_step(cap_pkg::LP_ANG_ROLL, longint'(t.sr) * 16, longint'(t.ar), ang_lim);
        end
        ry = stick_over_period(longint'(t.sy), longint'(t.per));
        d.p = 16'(pid_step(cap_pkg::LP_RATE_PITCH, rp, longint'(t.wp), rate_lim));
        d.r = 16'(pid_step(cap_pkg::LP_RATE_ROLL, rr, longint'(t.wr), rate_lim));
        d.y = 16'(pid_step(cap_pkg::LP_RATE_YAW, ry, longint'(t.wy), rate_lim));
        return d;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(cap_pkg::t_reg_idx idx, logic [63:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 6'(int'(idx) * 8); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            cap_pkg::REG_ANGLE_LIMIT: ang_lim = longint'(val[14:0]);
            cap_pkg::REG_RATE_LIMIT:  rate_lim = longint'(val[14:0]);
            cap_pkg::REG_ACROBATIC:   acro = val[0];
            default:                  gain_set[int'(idx)] = val[47:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (drive_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic send_tick(t_tick t, bit no_gap = 0);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.stick_pitch <= t.sp; in_ch.stick_roll <= t.sr; in_ch.stick_yaw <= t.sy;
        in_ch.angle_pitch <= t.ap; in_ch.angle_roll <= t.ar;
        in_ch.rate_pitch <= t.wp; in_ch.rate_roll <= t.wr; in_ch.rate_yaw <= t.wy;
        in_ch.period_us <= t.per;
        do @(posedge i_clk); while (!in_ch.ready);
        drive_q.push_back(predict_drive(t));
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_tick rand_tick();
        t_tick t;
        int r;
        t.sp = 11'($urandom); t.sr = 11'($urandom); t.sy = 11'($urandom);
        r = $urandom_range(0, 3);
        // mostly attitudes near the setpoint so the loops do not stay clamped
        if (r == 0) begin
            t.ap = 16'($urandom); t.ar = 16'($urandom); t.wp = 16'($urandom);
            t.wr = 16'($urandom); t.wy = 16'($urandom);
        end else begin
            t.ap = 16'(int'(t.sp) * 16 + $signed(12'($urandom)));
            t.ar = 16'(int'(t.sr) * 16 + $signed(12'($urandom)));
            t.wp = 16'($signed(12'($urandom))); t.wr = 16'($signed(12'($urandom)));
            t.wy = 16'($signed(12'($urandom)));
        end
        case ($urandom_range(0, 3))
            0: t.per = 16'($urandom);
            1: t.per = 16'($urandom_range(0, 4));
            default: t.per = 16'($urandom_range(1, 300));
        endcase
        return t;
    endfunction

    function automatic logic [47:0] rand_gains(int scale);
        logic [47:0] g;
        g = 48'({$urandom, $urandom});
        if (scale == 0) g = g & 48'h00FF_00FF_03FF;
        return g;
    endfunction

    task automatic test_directed();
        t_tick t;
        write_reg(cap_pkg::REG_GAINS_ANGLE_PITCH, 64'h0000_0040_0010_0200);
        write_reg(cap_pkg::REG_GAINS_ANGLE_ROLL, 64'h0000_0020_0008_0100);
        write_reg(cap_pkg::REG_GAINS_RATE_PITCH, 64'h0000_0010_0004_0180);
        write_reg(cap_pkg::REG_GAINS_RATE_ROLL, 64'h0000_0008_0002_0100);
        write_reg(cap_pkg::REG_GAINS_RATE_YAW, 64'h0000_0001_0001_0080);
        t = '{sp: 11'sd1023, sr: -11'sd1024, sy: 11'sd1023, ap: 16'sh7FFF,
              ar: -16'sh8000, wp: 16'sh7FFF, wr: -16'sh8000, wy: 0, per: 16'd1};
        send_tick(t);
        t = '{sp: -11'sd1024, sr: 11'sd1023, sy: -11'sd1024, ap: -16'sh8000,
              ar: 16'sh7FFF, wp: -16'sh8000, wr: 16'sh7FFF, wy: 16'sh7FFF, per: 16'd0};
        send_tick(t);
        t = '{sp: 0, sr: 0, sy: 11'sd5, ap: 0, ar: 0, wp: 0, wr: 0, wy: 0, per: 16'hFFFF};
        send_tick(t);
        t = '{sp: 11'sd3, sr: -11'sd3, sy: -11'sd7, ap: 16'sd40, ar: -16'sd40, wp: 16'sd1,
              wr: -16'sd1, wy: 16'sd2, per: 16'd3};
        send_tick(t);
        drain();
        write_reg(cap_pkg::REG_ACROBATIC, 64'd1);
        write_reg(cap_pkg::REG_RATE_LIMIT, 64'd100);
        t = '{sp: 11'sd1023, sr: -11'sd1024, sy: -11'sd1024, ap: 16'sd5, ar: 16'sd6,
              wp: 16'sd10, wr: -16'sd10, wy: 0, per: 16'd0};
        send_tick(t);
        t = '{sp: -11'sd7, sr: 11'sd7, sy: 11'sd7, ap: 0, ar: 0,
              wp: 0, wr: 0, wy: 0, per: 16'd3};
        send_tick(t);
        drain();
        write_reg(cap_pkg::REG_ACROBATIC, 64'd0);
        write_reg(cap_pkg::REG_ANGLE_LIMIT, 64'd0);
        write_reg(cap_pkg::REG_RATE_LIMIT, 64'd0);
        send_tick(rand_tick());
        send_tick(rand_tick());
        drain();
        write_reg(cap_pkg::REG_GAINS_RATE_PITCH, 64'hFFFF_FFFF_FFFF);
        write_reg(cap_pkg::REG_ANGLE_LIMIT, 64'h7FFF);
        write_reg(cap_pkg::REG_RATE_LIMIT, 64'h7FFF);
        send_tick(rand_tick());
        send_tick(rand_tick());
        drain();
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 16; ph++) begin
            for (int i = 0; i < cap_pkg::NLOOPS; i++)
                write_reg(cap_pkg::t_reg_idx'(i), 64'(rand_gains((ph % 4 == 3) ? 1 : 0)));
            write_reg(cap_pkg::REG_ANGLE_LIMIT,
                      (ph % 5 == 0) ? 64'h7FFF : 64'($urandom_range(0, 4000)));
            write_reg(cap_pkg::REG_RATE_LIMIT,
                      (ph % 7 == 1) ? 64'd0 : 64'($urandom_range(0, 32767)));
            write_reg(cap_pkg::REG_ACROBATIC, 64'(ph % 2));
            for (int n = 0; n < 100; n++) send_tick(rand_tick());
            drain();
        end
    endtask

    // keep the input full while the receiver holds off
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 20; n++) send_tick(rand_tick(), 1'b1);
        join
        drain();
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (drive_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected drive result");
            end else begin
                t_drive e;
                e = drive_q.pop_front();
                if (e.p !== out_ch.drive_pitch || e.r !== out_ch.drive_roll ||
                    e.y !== out_ch.drive_yaw) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("drive mismatch: exp %0d %0d %0d got %0d %0d %0d",
                                 e.p, e.r, e.y, out_ch.drive_pitch, out_ch.drive_roll,
                                 out_ch.drive_yaw);
                end
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off) out_ch.ready <= 1'b0;
            else if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
                out_ch.ready <= (stall == 0);
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel ||
            !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < cap_pkg::NLOOPS; i++) begin
            gain_set[i] = '0;
            integ[i] = 0;
            last_meas[i] = 0;
        end
        ang_lim = longint'(cap_pkg::LIMIT_RESET);
        rate_lim = longint'(cap_pkg::LIMIT_RESET);
        acro = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        if (mismatches == 0 && drive_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
